### rtl/rectangle_light_grid_engine_core_defines.svh
// Assertion macros for the rectangle light grid engine.
// Included by rlge_back, the RTL file that carries concurrent checks; needs no other file.
`ifndef RECTANGLE_LIGHT_GRID_ENGINE_CORE_DEFINES_SVH
`define RECTANGLE_LIGHT_GRID_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checks off while reset is asserted.
`define RLGE_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("rlge same-cycle check failed");

// Next-cycle implication, checks off while reset is asserted.
`define RLGE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("rlge next-cycle check failed");

`endif

### rtl/rlge_pkg.sv
// Shared constants, mode codes and the command word type of the light grid engine.
// Used by the front end, the command queue and the back end; depends on nothing.
`default_nettype none

package rlge_pkg;

	// Grid and field sizes
	localparam int GRID_SIDE   = 1024;
	localparam int BRIGHT_W    = 16;
	localparam int MODE_W      = 2;
	localparam int COORD_W     = 10;
	localparam int LIT_W       = 21;
	localparam int SUM_W       = 36;

	// Derived storage sizes
	localparam int IDX_W       = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int MEM_DEPTH   = 1 << ADDR_W;
	localparam int CELL_W      = BRIGHT_W + 1;
	localparam logic [31:0] COORD_LIM = 32'(GRID_SIDE - 1);

	// Command queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_TOGGLE = 2'd0,
		MODE_ON     = 2'd1,
		MODE_OFF    = 2'd2
	} rlge_mode_t;

	// Classified command: bounds already clamped to the grid
	typedef struct packed {
		rlge_mode_t       mode;
		logic             noop;
		logic [IDX_W-1:0] r0;
		logic [IDX_W-1:0] c0;
		logic [IDX_W-1:0] r1;
		logic [IDX_W-1:0] c1;
	} rlge_cmd_t;

endpackage

`default_nettype wire

### rtl/rlge_front.sv
// Front end: classifies an incoming command word and pushes it into the queue.
// Depends on rlge_pkg.
`default_nettype none

module rlge_front (
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [rlge_pkg::MODE_W-1:0]    mode,
	input  logic [rlge_pkg::COORD_W-1:0]   row_start,
	input  logic [rlge_pkg::COORD_W-1:0]   col_start,
	input  logic [rlge_pkg::COORD_W-1:0]   row_end,
	input  logic [rlge_pkg::COORD_W-1:0]   col_end,
	input  logic                           clearing,
	input  logic                           q_full,
	output logic                           push,
	output rlge_pkg::rlge_cmd_t            push_cmd
);
	import rlge_pkg::*;

	logic [31:0] r0_ext;
	logic [31:0] c0_ext;
	logic [31:0] r1_clamp;
	logic [31:0] c1_clamp;
	logic        bad_mode;
	logic        empty;

	// Hold off commands while the grid is being cleared or the queue is full
	assign cmd_stall = q_full | clearing;
	assign push      = cmd_valid & ~cmd_stall;

	// Clamp the end bounds to the grid, flag empty ranges and unused modes
	always_comb begin
		r0_ext   = 32'(row_start);
		c0_ext   = 32'(col_start);
		r1_clamp = (32'(row_end) > COORD_LIM) ? COORD_LIM : 32'(row_end);
		c1_clamp = (32'(col_end) > COORD_LIM) ? COORD_LIM : 32'(col_end);
		bad_mode = !(mode inside {MODE_TOGGLE, MODE_ON, MODE_OFF});
		empty    = (r0_ext > r1_clamp) || (c0_ext > c1_clamp);

		push_cmd.mode = rlge_mode_t'(mode);
		push_cmd.noop = bad_mode | empty;
		push_cmd.r0   = IDX_W'(r0_ext);
		push_cmd.c0   = IDX_W'(c0_ext);
		push_cmd.r1   = IDX_W'(r1_clamp);
		push_cmd.c1   = IDX_W'(c1_clamp);
	end

endmodule

`default_nettype wire

### rtl/rlge_queue.sv
// Short command queue between the front end and the back end.
// Depends on rlge_pkg.
`default_nettype none

module rlge_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rlge_pkg::rlge_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output rlge_pkg::rlge_cmd_t pop_cmd
);
	import rlge_pkg::*;

	rlge_cmd_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic [QPTR_W-1:0]  wr_ptr_nxt;
	logic [QPTR_W-1:0]  rd_ptr_nxt;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entries_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	// Wrap the pointers at the queue depth
	always_comb begin
		wr_ptr_nxt = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
		rd_ptr_nxt = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/rlge_back.sv
// Back end: clears the cell store after reset, walks each command's rectangle one
// cell per cycle with a read-modify-write, keeps the totals and registers the result.
// Depends on rlge_pkg and rectangle_light_grid_engine_core_defines.svh.
`default_nettype none
`include "rectangle_light_grid_engine_core_defines.svh"

module rlge_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rlge_pkg::rlge_cmd_t           q_cmd,
	output logic                          q_pop,
	output logic                          clearing,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [rlge_pkg::LIT_W-1:0]    lit_count,
	output logic [rlge_pkg::SUM_W-1:0]    brightness_sum
);
	import rlge_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = {BRIGHT_W{1'b1}};
	localparam logic [ADDR_W-1:0]   ADDR_LAST  = {ADDR_W{1'b1}};

	state_t              state_q;
	rlge_cmd_t           cmd_q;
	logic [IDX_W-1:0]    row_q;
	logic [IDX_W-1:0]    col_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                res_valid_q;
	logic [LIT_W-1:0]    lit_count_q;
	logic [SUM_W-1:0]    brightness_sum_q;

	logic                vld_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [CELL_W-1:0]   rdata_s1;
	logic [LIT_W-1:0]    lit_total_q;
	logic [SUM_W-1:0]    bright_total_q;

	logic [CELL_W-1:0]   mem [MEM_DEPTH];

	logic                slot_free;
	logic                last_cell;
	logic                in_rect;
	logic [ADDR_W-1:0]   rd_addr;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [CELL_W-1:0]   mem_wdata;

	logic                on_old;
	logic                on_new;
	logic [BRIGHT_W-1:0] b_old;
	logic [BRIGHT_W-1:0] b_new;
	logic [BRIGHT_W:0]   b_up2;
	logic [BRIGHT_W+1:0] b_diff;
	logic [SUM_W-1:0]    b_delta;
	logic [LIT_W-1:0]    lit_next;

	assign clearing       = (state_q == ST_CLEAR);
	assign q_pop          = (state_q == ST_IDLE) && q_valid;
	assign slot_free      = !res_valid_q || !res_stall;
	assign last_cell      = (row_q == cmd_q.r1) && (col_q == cmd_q.c1);
	assign in_rect        = (row_q >= cmd_q.r0) && (row_q <= cmd_q.r1) &&
	                        (col_q >= cmd_q.c0) && (col_q <= cmd_q.c1);
	assign rd_addr        = {row_q, col_q};
	assign res_valid      = res_valid_q;
	assign lit_count      = lit_count_q;
	assign brightness_sum = brightness_sum_q;

	// Compute the new cell value and the change to the totals
	always_comb begin
		on_old = rdata_s1[BRIGHT_W];
		b_old  = rdata_s1[BRIGHT_W-1:0];
		b_up2  = {1'b0, b_old} + (BRIGHT_W+1)'(2);
		case (cmd_q.mode)
			MODE_TOGGLE: begin
				on_new = !on_old;
				b_new  = (b_up2 > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX : b_up2[BRIGHT_W-1:0];
			end
			MODE_ON: begin
				on_new = 1'b1;
				b_new  = (b_old == BRIGHT_MAX) ? b_old : b_old + BRIGHT_W'(1);
			end
			MODE_OFF: begin
				on_new = 1'b0;
				b_new  = (b_old == '0) ? b_old : b_old - BRIGHT_W'(1);
			end
			default: begin
				on_new = on_old;
				b_new  = b_old;
			end
		endcase
		b_diff  = {2'b00, b_new} - {2'b00, b_old};
		b_delta = {{(SUM_W-BRIGHT_W-2){b_diff[BRIGHT_W+1]}}, b_diff};
		if (on_new == on_old) begin
			lit_next = lit_total_q;
		end else if (on_new) begin
			lit_next = lit_total_q + LIT_W'(1);
		end else begin
			lit_next = lit_total_q - LIT_W'(1);
		end
	end

	// Select the write port: clearing sweep or write-back of stage 1
	always_comb begin
		mem_we    = clearing | vld_s1;
		mem_waddr = clearing ? clr_addr_q : addr_s1;
		mem_wdata = clearing ? '0 : {on_new, b_new};
	end

	// Cell store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Track the read in flight and fold each written cell into the totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			addr_s1        <= '0;
			lit_total_q    <= '0;
			bright_total_q <= '0;
		end else begin
			vld_s1  <= (state_q == ST_WALK);
			addr_s1 <= rd_addr;
			if (vld_s1) begin
				lit_total_q    <= lit_next;
				bright_total_q <= bright_total_q + b_delta;
			end
		end
	end

	// Sequencer: clear, take a command, walk its cells, drain, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			cmd_q            <= '0;
			row_q            <= '0;
			col_q            <= '0;
			clr_addr_q       <= '0;
			res_valid_q      <= 1'b0;
			lit_count_q      <= '0;
			brightness_sum_q <= '0;
		end else begin
			// Drop a taken result unless the report state loads a new one
			if (res_valid_q && !res_stall && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_cmd;
						row_q   <= q_cmd.r0;
						col_q   <= q_cmd.c0;
						state_q <= q_cmd.noop ? ST_DONE : ST_WALK;
					end
				end
				ST_WALK: begin
					if (last_cell) begin
						state_q <= ST_DRAIN;
					end else if (col_q == cmd_q.c1) begin
						col_q <= cmd_q.c0;
						row_q <= row_q + IDX_W'(1);
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q      <= 1'b1;
						lit_count_q      <= lit_total_q;
						brightness_sum_q <= bright_total_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Pipeline is empty before the next command starts its reads
	`RLGE_ASSERT_IMPLY(a_idle_drained, clk, arst_n, state_q == ST_IDLE, !vld_s1)
	// Walk position stays inside the command's rectangle
	`RLGE_ASSERT_IMPLY(a_walk_in_rect, clk, arst_n, state_q == ST_WALK, in_rect)
	// A result only appears out of the report state
	`RLGE_ASSERT_NEXT(a_result_from_done, clk, arst_n, !res_valid_q && (state_q != ST_DONE), !res_valid_q)
	// Nothing moves through the cell pipeline during the clearing sweep
	`RLGE_ASSERT_IMPLY(a_clear_quiet, clk, arst_n, state_q == ST_CLEAR, !vld_s1 && !res_valid_q)

endmodule

`default_nettype wire

### rtl/rectangle_light_grid_engine_core.sv
// Top level of the rectangle light grid engine: front end, command queue, back end.
// Depends on rlge_pkg, rlge_front, rlge_queue and rlge_back.
//
//  port group   direction  handshake               word
//  cmd          in         cmd_valid / cmd_stall   mode, row_start, col_start, row_end, col_end
//  res          out        res_valid / res_stall   lit_count, brightness_sum
//
// After reset the cell store is swept clear, all 1,048,576 cells, one cell a cycle,
// with cmd_stall high. A command that changes no cell goes from the queue straight
// to the report state; one covering R rows by C columns walks its R*C cells through
// the single read-modify-write of one cell a cycle on the cell store, then drains.
// The queue holds two commands, so while a result waits on res_stall cmd_stall
// stays low until two more commands are queued behind it.
`default_nettype none

module rectangle_light_grid_engine_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [rlge_pkg::MODE_W-1:0]  mode,
	input  logic [rlge_pkg::COORD_W-1:0] row_start,
	input  logic [rlge_pkg::COORD_W-1:0] col_start,
	input  logic [rlge_pkg::COORD_W-1:0] row_end,
	input  logic [rlge_pkg::COORD_W-1:0] col_end,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [rlge_pkg::LIT_W-1:0]   lit_count,
	output logic [rlge_pkg::SUM_W-1:0]   brightness_sum
);
	import rlge_pkg::*;

	logic      clearing;
	logic      q_full;
	logic      push;
	rlge_cmd_t push_cmd;
	logic      q_valid;
	logic      q_pop;
	rlge_cmd_t q_cmd;

	// Classify and enqueue commands
	rlge_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.mode      (mode),
		.row_start (row_start),
		.col_start (col_start),
		.row_end   (row_end),
		.col_end   (col_end),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Decouple front and back
	rlge_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_cmd   (q_cmd)
	);

	// Walk cells, keep totals, report
	rlge_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop),
		.clearing       (clearing),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.lit_count      (lit_count),
		.brightness_sum (brightness_sum)
	);

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for rectangle_light_grid_engine_core: rectangle commands in, totals out.
// Keeps its own copy of the cell grid and running totals; depends on rlge_pkg and the core RTL.
`default_nettype none

module testbench;
	import rlge_pkg::*;

	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [BRIGHT_W:0] BRIGHT_MAX = (BRIGHT_W+1)'((1 << BRIGHT_W) - 1);
	localparam int SAT_CELL = 9;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [COORD_W-1:0] r0;
		logic [COORD_W-1:0] c0;
		logic [COORD_W-1:0] r1;
		logic [COORD_W-1:0] c1;
		bit                 drain;
	} grid_cmd_t;

	typedef struct {
		logic [LIT_W-1:0] lit;
		logic [SUM_W-1:0] sum;
	} grid_totals_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	logic [MODE_W-1:0]  mode = '0;
	logic [COORD_W-1:0] row_start = '0;
	logic [COORD_W-1:0] col_start = '0;
	logic [COORD_W-1:0] row_end = '0;
	logic [COORD_W-1:0] col_end = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [LIT_W-1:0]   lit_count;
	logic [SUM_W-1:0]   brightness_sum;

	// Shadow grid and running totals
	bit [BRIGHT_W-1:0] cell_level [CELLS];
	bit                cell_lit [CELLS];
	bit [LIT_W-1:0]    lit_shadow = '0;
	bit [SUM_W:0]      bright_shadow = '0;

	grid_cmd_t    cmd_pending [$];
	grid_totals_t totals_due [$];
	int           cmds_taken = 0;
	int           results_seen = 0;
	int           mismatch_count = 0;

	rectangle_light_grid_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.mode           (mode),
		.row_start      (row_start),
		.col_start      (col_start),
		.row_end        (row_end),
		.col_end        (col_end),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.lit_count      (lit_count),
		.brightness_sum (brightness_sum)
	);

	// Apply one command to the shadow grid and return the totals it leaves
	function automatic grid_totals_t apply_rectangle(grid_cmd_t c);
		int unsigned lim, r_hi, c_hi, row, col, idx;
		logic [BRIGHT_W:0] lvl, nxt;
		bit was_on, now_on;
		grid_totals_t t;
		lim = GRID_SIDE - 1;
		r_hi = (32'(c.r1) > lim) ? lim : 32'(c.r1);
		c_hi = (32'(c.c1) > lim) ? lim : 32'(c.c1);
		if (c.mode != MODE_UNUSED && 32'(c.r0) <= r_hi && 32'(c.c0) <= c_hi) begin
			for (row = 32'(c.r0); row <= r_hi; row++) begin
				for (col = 32'(c.c0); col <= c_hi; col++) begin
					idx = row * GRID_SIDE + col;
					lvl = {1'b0, cell_level[idx]};
					was_on = cell_lit[idx];
					case (c.mode)
						MODE_TOGGLE: begin
							now_on = !was_on;
							nxt = (lvl + (BRIGHT_W+1)'(2) > BRIGHT_MAX) ? BRIGHT_MAX
								: lvl + (BRIGHT_W+1)'(2);
						end
						MODE_ON: begin
							now_on = 1'b1;
							nxt = (lvl == BRIGHT_MAX) ? BRIGHT_MAX : lvl + (BRIGHT_W+1)'(1);
						end
						MODE_OFF: begin
							now_on = 1'b0;
							nxt = (lvl == '0) ? '0 : lvl - (BRIGHT_W+1)'(1);
						end
						default: begin
							now_on = was_on;
							nxt = lvl;
						end
					endcase
					if (now_on != was_on)
						lit_shadow = now_on ? lit_shadow + 1'b1 : lit_shadow - 1'b1;
					bright_shadow = bright_shadow - lvl + nxt;
					cell_level[idx] = nxt[BRIGHT_W-1:0];
					cell_lit[idx] = now_on;
				end
			end
		end
		t.lit = lit_shadow;
		t.sum = bright_shadow[SUM_W-1:0];
		return t;
	endfunction

	// Hold both sides busy through one long stretch of traffic
	function automatic bit quiet_stretch(int n);
		return n >= 30 && n < 60;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatch_count++;
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
	endtask

	task automatic add_cmd(logic [MODE_W-1:0] m, int r0, int c0, int r1, int c1, bit drain);
		grid_cmd_t c;
		c.mode = m;
		c.r0 = r0[COORD_W-1:0];
		c.c0 = c0[COORD_W-1:0];
		c.r1 = r1[COORD_W-1:0];
		c.c1 = c1[COORD_W-1:0];
		c.drain = drain;
		cmd_pending.push_back(c);
	endtask

	// Send command words: predict on acceptance, then present the next one
	always @(posedge clk or negedge arst_n) begin : drive_commands
		grid_cmd_t taken;
		grid_cmd_t queued;
		bit hold_off;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				taken.mode = mode;
				taken.r0 = row_start;
				taken.c0 = col_start;
				taken.r1 = row_end;
				taken.c1 = col_end;
				taken.drain = 1'b0;
				totals_due.push_back(apply_rectangle(taken));
				cmds_taken++;
			end
			if (!cmd_valid || !cmd_stall) begin
				hold_off = cmd_pending.size() == 0
					|| (cmd_pending[0].drain && totals_due.size() != 0)
					|| (!quiet_stretch(cmds_taken) && $urandom_range(0, 99) < 26);
				if (hold_off) begin
					cmd_valid <= 1'b0;
				end else begin
					queued = cmd_pending.pop_front();
					cmd_valid <= 1'b1;
					mode <= queued.mode;
					row_start <= queued.r0;
					col_start <= queued.c0;
					row_end <= queued.r1;
					col_end <= queued.c1;
				end
			end
		end
	end

	// Take result words and compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_results
		grid_totals_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				results_seen++;
				if (totals_due.size() == 0) begin
					report_mismatch("result with none pending, lit_count", lit_count, 0);
				end else begin
					want = totals_due.pop_front();
					if (lit_count !== want.lit)
						report_mismatch("lit_count", lit_count, want.lit);
					if (brightness_sum !== want.sum)
						report_mismatch("brightness_sum", brightness_sum, want.sum);
				end
			end
			res_stall <= !quiet_stretch(results_seen) && $urandom_range(0, 99) < 26;
		end
	end

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Overall time limit, well past the clearing sweep and every command
	initial begin
		#30000000;
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		int r0, c0, r1, c1, kind, n;
		logic [MODE_W-1:0] m;

		// Directed: corners, full-length strips, empty ranges, unused mode, overlaps
		add_cmd(MODE_TOGGLE, 0, 0, 0, 0, 1'b0);
		add_cmd(MODE_ON, 1023, 1023, 1023, 1023, 1'b0);
		add_cmd(MODE_OFF, 0, 0, 0, 0, 1'b0);
		add_cmd(MODE_OFF, 0, 0, 0, 0, 1'b0);
		add_cmd(MODE_OFF, 0, 0, 0, 0, 1'b0);
		add_cmd(MODE_TOGGLE, 0, 1023, 1023, 1023, 1'b0);
		add_cmd(MODE_ON, 1023, 0, 1023, 1023, 1'b0);
		add_cmd(MODE_OFF, 0, 0, 1023, 0, 1'b0);
		add_cmd(MODE_TOGGLE, 1023, 0, 0, 1023, 1'b0);
		add_cmd(MODE_ON, 0, 5, 1023, 4, 1'b0);
		add_cmd(MODE_OFF, 1023, 1023, 0, 0, 1'b0);
		add_cmd(MODE_UNUSED, 0, 0, 1023, 1023, 1'b0);
		add_cmd(MODE_UNUSED, 3, 3, 4, 4, 1'b0);
		add_cmd(MODE_TOGGLE, 2, 2, 4, 4, 1'b0);
		add_cmd(MODE_TOGGLE, 3, 3, 5, 5, 1'b0);
		add_cmd(MODE_ON, 0, 0, 7, 7, 1'b0);
		add_cmd(MODE_OFF, 2, 2, 3, 3, 1'b0);
		add_cmd(MODE_TOGGLE, 1023, 512, 1023, 515, 1'b0);
		add_cmd(MODE_TOGGLE, 'h2aa, 'h155, 'h2ab, 'h156, 1'b0);
		add_cmd(MODE_ON, 'h155, 'h2aa, 'h156, 'h2ab, 1'b0);

		// Pile toggles and turn-ons onto one cell after every result is in, then turn it off
		for (n = 0; n < 4; n++)
			add_cmd(MODE_TOGGLE, SAT_CELL, SAT_CELL, SAT_CELL, SAT_CELL, n == 0);
		add_cmd(MODE_ON, SAT_CELL, SAT_CELL, SAT_CELL, SAT_CELL, 1'b0);
		add_cmd(MODE_ON, SAT_CELL, SAT_CELL, SAT_CELL, SAT_CELL, 1'b0);
		add_cmd(MODE_OFF, SAT_CELL, SAT_CELL, SAT_CELL, SAT_CELL, 1'b0);

		// Random: mostly small rectangles, half of them overlapping near the busy cell
		for (n = 0; n < 73; n++) begin
			kind = $urandom_range(0, 99);
			m = MODE_W'($urandom_range(0, 2));
			if (kind < 50) begin
				r0 = $urandom_range(0, 15);
				c0 = $urandom_range(0, 15);
				r1 = r0 + $urandom_range(0, 5);
				c1 = c0 + $urandom_range(0, 5);
			end else if (kind < 70) begin
				r0 = $urandom_range(0, 1023);
				c0 = $urandom_range(0, 1023);
				r1 = r0 + $urandom_range(0, 7);
				c1 = c0 + $urandom_range(0, 7);
			end else if (kind < 78) begin
				r0 = $urandom_range(0, 1023);
				c0 = $urandom_range(0, 1023);
				r1 = r0 + $urandom_range(16, 63);
				c1 = c0 + $urandom_range(16, 63);
			end else if (kind < 86) begin
				r1 = $urandom_range(0, 1022);
				r0 = $urandom_range(r1 + 1, 1023);
				c0 = $urandom_range(0, 1023);
				c1 = $urandom_range(0, 1023);
				if (kind[0]) begin
					r0 = c0;
					r1 = c1;
					c1 = $urandom_range(0, 1022);
					c0 = $urandom_range(c1 + 1, 1023);
				end
			end else if (kind < 92) begin
				m = MODE_UNUSED;
				r0 = $urandom_range(0, 1023);
				c0 = $urandom_range(0, 1023);
				r1 = $urandom_range(0, 1023);
				c1 = $urandom_range(0, 1023);
			end else begin
				r0 = $urandom_range(0, 1023);
				r1 = $urandom_range(0, 1023);
				c0 = $urandom_range(0, 1023);
				c1 = c0;
			end
			if (r1 > 1023)
				r1 = 1023;
			if (c1 > 1023)
				c1 = 1023;
			add_cmd(m, r0, c0, r1, c1, n == 0 || $urandom_range(0, 99) < 3);
		end

		// Hold reset, then release it
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last word out, then let any stray result show up
		do
			@(negedge clk);
		while (cmd_pending.size() != 0 || cmd_valid || totals_due.size() != 0);
		repeat (20) @(negedge clk);

		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/rlge_pkg.sv
rtl/rlge_front.sv
rtl/rlge_queue.sv
rtl/rlge_back.sv
rtl/rectangle_light_grid_engine_core.sv
sim/testbench.sv
